// ===== rtl/avm_pkg.sv =====
// shared types, constants and state codes of the averaging voltmeter
package avm_pkg;

   localparam int CodeWidth    = 12;
   localparam int GroupWidth   = 14;
   localparam int TotalWidth   = 16;
   localparam int RefWidth     = 13;
   localparam int ProdWidth    = TotalWidth + RefWidth;
   localparam int MvShift      = 15;            // divide by 2048 * 16
   localparam int MvWidth      = 14;
   localparam int GroupLast    = 3;             // four codes per group
   localparam int TotalLast    = 15;            // sixteen groups per line

   localparam logic [RefWidth-1:0]   RefMvReset = 13'd3300;
   localparam logic [CodeWidth:0]    GroupLimit = 13'd4096;
   localparam logic [MvWidth-1:0]    Thousand   = 14'd1000;
   localparam logic [MvWidth-1:0]    Hundred    = 14'd100;
   localparam logic [MvWidth-1:0]    Ten        = 14'd10;
   localparam logic [7:0]            AsciiZero  = 8'h30;
   localparam logic [7:0]            AsciiDot   = 8'h2E;
   localparam logic [7:0]            AsciiV     = 8'h76;
   localparam logic [7:0]            LineEnd    = 8'h0A;

   typedef struct packed {
      logic [7:0] adc_high;
      logic [7:0] adc_low;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   // one finished line waiting for formatting
   typedef struct packed {
      logic [TotalWidth-1:0] total;
      logic [RefWidth-1:0]   ref_mv;
   } line_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_THOU,
      BK_HUND,
      BK_TENS,
      BK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      CH_ONES,
      CH_DOT,
      CH_HUND,
      CH_TENS,
      CH_UNITS,
      CH_VOLT,
      CH_END
   } char_sel_type;

endpackage

// ===== rtl/avm_front.sv =====
// sample accumulation: joins bytes into codes, sums groups and lines
module avm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  avm_pkg::req_type      req_data,
   input  logic                  csr_wr_en,
   input  logic [12:0]           csr_wr_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output avm_pkg::line_type     push_data
);
   import avm_pkg::*;

   logic [RefWidth-1:0]   ref_mv_ff,      ref_mv_in;
   logic [GroupWidth-1:0] group_sum_ff,   group_sum_in;
   logic [1:0]            group_count_ff, group_count_in;
   logic [TotalWidth-1:0] total_sum_ff,   total_sum_in;
   logic [3:0]            total_count_ff, total_count_in;

   logic [CodeWidth-1:0]  code;
   logic [GroupWidth-1:0] sum_new;
   logic [CodeWidth-1:0]  grp;
   logic [TotalWidth-1:0] total_new;
   logic                  group_done;
   logic                  line_done;
   logic                  accept;

   assign group_done = (group_count_ff == 2'(GroupLast));
   assign line_done  = group_done && (total_count_ff == 4'(TotalLast));
   // only the sample that closes a line needs room in the queue
   assign req_ready  = push_ready || !line_done;
   assign accept     = req_valid && req_ready;

   always_comb begin
      code      = {req_data.adc_high, req_data.adc_low[7:4]};
      sum_new   = group_sum_ff + GroupWidth'(code);
      grp       = sum_new[GroupWidth-1:2];
      if ({1'b0, grp} > GroupLimit) begin
         grp = '0;
      end
      total_new = total_sum_ff + TotalWidth'(grp);

      ref_mv_in      = csr_wr_en ? csr_wr_data : ref_mv_ff;
      group_sum_in   = group_sum_ff;
      group_count_in = group_count_ff;
      total_sum_in   = total_sum_ff;
      total_count_in = total_count_ff;

      if (accept) begin
         if (!group_done) begin
            group_sum_in   = sum_new;
            group_count_in = group_count_ff + 2'd1;
         end else begin
            group_sum_in   = '0;
            group_count_in = '0;
            if (line_done) begin
               total_sum_in   = '0;
               total_count_in = '0;
            end else begin
               total_sum_in   = total_new;
               total_count_in = total_count_ff + 4'd1;
            end
         end
      end

      push_valid       = accept && line_done;
      push_data.total  = total_new;
      push_data.ref_mv = ref_mv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mv_ff      <= RefMvReset;
         group_sum_ff   <= '0;
         group_count_ff <= '0;
         total_sum_ff   <= '0;
         total_count_ff <= '0;
      end else begin
         ref_mv_ff      <= ref_mv_in;
         group_sum_ff   <= group_sum_in;
         group_count_ff <= group_count_in;
         total_sum_ff   <= total_sum_in;
         total_count_ff <= total_count_in;
      end
   end

endmodule

// ===== rtl/avm_queue.sv =====
// two-entry queue of finished lines between accumulation and formatting
module avm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  avm_pkg::line_type     push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output avm_pkg::line_type     pop_data
);
   import avm_pkg::*;

   line_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        do_push;
   logic        do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/avm_back.sv =====
// line formatting: scale to millivolts, split into digits, send characters
module avm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  avm_pkg::line_type     pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output avm_pkg::rsp_type      rsp_data
);
   import avm_pkg::*;

   back_state_type        state_ff, state_in;
   logic [TotalWidth-1:0] total_ff, total_in;
   logic [RefWidth-1:0]   ref_ff,   ref_in;
   logic [MvWidth-1:0]    rem_ff,   rem_in;
   logic [4:0]            ones_ff,  ones_in;
   logic [3:0]            hund_ff,  hund_in;
   logic [3:0]            tens_ff,  tens_in;
   char_sel_type          sel_ff,   sel_in;
   logic [ProdWidth-1:0]  prod;

   assign prod = ProdWidth'(total_ff) * ProdWidth'(ref_ff);

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      ref_in    = ref_ff;
      rem_in    = rem_ff;
      ones_in   = ones_ff;
      hund_in   = hund_ff;
      tens_in   = tens_ff;
      sel_in    = sel_ff;
      pop_ready = 1'b0;
      rsp_valid = 1'b0;

      case (sel_ff)
         CH_ONES:  rsp_data.out_char = AsciiZero + 8'(ones_ff);
         CH_DOT:   rsp_data.out_char = AsciiDot;
         CH_HUND:  rsp_data.out_char = AsciiZero + 8'(hund_ff);
         CH_TENS:  rsp_data.out_char = AsciiZero + 8'(tens_ff);
         CH_UNITS: rsp_data.out_char = AsciiZero + 8'(rem_ff[3:0]);
         CH_VOLT:  rsp_data.out_char = AsciiV;
         CH_END:   rsp_data.out_char = LineEnd;
         default:  rsp_data.out_char = LineEnd;
      endcase
      rsp_data.last_char = (sel_ff == CH_END);

      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               total_in = pop_data.total;
               ref_in   = pop_data.ref_mv;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            rem_in   = prod[MvShift +: MvWidth];
            ones_in  = '0;
            hund_in  = '0;
            tens_in  = '0;
            state_in = BK_THOU;
         end
         // digits by repeated subtraction
         BK_THOU: begin
            if (rem_ff >= Thousand) begin
               rem_in  = rem_ff - Thousand;
               ones_in = ones_ff + 5'd1;
            end else begin
               state_in = BK_HUND;
            end
         end
         BK_HUND: begin
            if (rem_ff >= Hundred) begin
               rem_in  = rem_ff - Hundred;
               hund_in = hund_ff + 4'd1;
            end else begin
               state_in = BK_TENS;
            end
         end
         BK_TENS: begin
            if (rem_ff >= Ten) begin
               rem_in  = rem_ff - Ten;
               tens_in = tens_ff + 4'd1;
            end else begin
               sel_in   = CH_ONES;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sel_ff == CH_END) begin
                  state_in = BK_IDLE;
               end else begin
                  sel_in = char_sel_type'(sel_ff + 3'd1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         sel_ff   <= CH_ONES;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      ref_ff   <= ref_in;
      rem_ff   <= rem_in;
      ones_ff  <= ones_in;
      hund_ff  <= hund_in;
      tens_ff  <= tens_in;
   end

endmodule

// ===== rtl/adc_average_voltmeter_ascii.sv =====
// top level of the averaging voltmeter with ascii line output
//
//   channel  direction  handshake           payload
//   req      in         req_valid/ready     req_data (adc_high, adc_low)
//   rsp      out        rsp_valid/ready     rsp_data (out_char, last_char)
//   csr      in         csr_wr_en           csr_wr_data (ref_mv)
//
// one sample is taken per cycle, but for a line-closing sample stalled on a full queue; every 64th sample closes a line
// in the formatter a line goes through a multiply, then digit
// subtraction loops of up to 16, 9 and 9 steps, and then 7 transactions on rsp
// two finished lines can wait in the queue; the sample that closes a line
// stalls only while the queue is full
// reset clears sums, counters and the queue and sets ref_mv to 3300
module adc_average_voltmeter_ascii (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  avm_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output avm_pkg::rsp_type      rsp_data,
   input  logic                  csr_wr_en,
   input  logic [12:0]           csr_wr_data
);
   import avm_pkg::*;

   logic     push_valid;
   logic     push_ready;
   line_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   line_type pop_data;

   avm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   avm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   avm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
